// ===== hdl/twma_pkg.sv =====
// Shared types and constants of the two-axis windowed moving average core.
package twma_pkg;

  // Ring depth: entries averaged per axis (a power of two, 2 to 256)
  localparam int AVG_DEPTH = 16;
  localparam int SLOT_W    = $clog2(AVG_DEPTH);
  localparam int SUM_W     = 8 + SLOT_W;

  // Queue between the front and back parts
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] SAT_MAX = 8'd255;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_TICKS = 3'd0,
    REG_GAIN       = 3'd1,
    REG_X_LOWER    = 3'd2,
    REG_X_UPPER    = 3'd3,
    REG_Y_LOWER    = 3'd4,
    REG_Y_UPPER    = 3'd5,
    REG_SLOPE      = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0] RST_SKIP_TICKS = 16'd0;
  localparam logic [7:0]  RST_GAIN       = 8'd1;
  localparam logic [7:0]  RST_X_LOWER    = 8'd80;
  localparam logic [7:0]  RST_X_UPPER    = 8'd86;
  localparam logic [7:0]  RST_Y_LOWER    = 8'd78;
  localparam logic [7:0]  RST_Y_UPPER    = 8'd84;
  localparam logic [7:0]  RST_SLOPE      = 8'd42;

  typedef struct packed {
    logic [15:0] skip_ticks;
    logic [7:0]  gain;
    logic [7:0]  x_lower;
    logic [7:0]  x_upper;
    logic [7:0]  y_lower;
    logic [7:0]  y_upper;
    logic [7:0]  slope;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] x_sample;
    logic [7:0] y_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] x_average;
    logic [7:0] y_average;
    logic       sample_taken;
  } out_item_t;

  // Classified tick handed from front to back
  typedef struct packed {
    logic [7:0] x_mapped;
    logic [7:0] y_mapped;
    logic       taken;
  } q_item_t;

  // Back part sequencer
  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_UPDATE = 2'd1,
    BK_HOLD   = 2'd2
  } back_state_t;

endpackage

// ===== hdl/two_axis_windowed_moving_average_core.sv =====
// Top level of the two-axis windowed moving average core.
// Each input item is one tick with an 8-bit X and Y sample, and each tick gives
// exactly one result: per axis, floor(ring sum / depth) times gain, saturated at
// 255, plus a flag telling whether the tick was sampled. The front part decides
// sampling with the skip counter and maps the samples through the window in the
// accepting cycle, then queues the tick. The back part takes every tick when the
// result side is free: a sampling tick goes through the ring read and then the
// sum update and ring write, a skipped tick through the pop and then the result
// load. A stalled result holds the back part, and the input stalls once the queue
// is full. Rings read as zero after reset through per-slot valid bits, so no
// clearing pass is needed.
// Configuration writes are taken every cycle and belong only to idle periods.
module two_axis_windowed_moving_average_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  twma_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output twma_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [twma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twma_pkg::CFG_DATA_W-1:0]     cfg_data
);

  twma_pkg::cfg_regs_t cfg_r;
  logic                q_full;
  logic                q_push;
  twma_pkg::q_item_t   q_push_item;
  logic                q_valid;
  logic                q_pop;
  twma_pkg::q_item_t   q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_ticks <= twma_pkg::RST_SKIP_TICKS;
      cfg_r.gain       <= twma_pkg::RST_GAIN;
      cfg_r.x_lower    <= twma_pkg::RST_X_LOWER;
      cfg_r.x_upper    <= twma_pkg::RST_X_UPPER;
      cfg_r.y_lower    <= twma_pkg::RST_Y_LOWER;
      cfg_r.y_upper    <= twma_pkg::RST_Y_UPPER;
      cfg_r.slope      <= twma_pkg::RST_SLOPE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        twma_pkg::REG_SKIP_TICKS: cfg_r.skip_ticks <= cfg_data;
        twma_pkg::REG_GAIN:       cfg_r.gain       <= cfg_data[7:0];
        twma_pkg::REG_X_LOWER:    cfg_r.x_lower    <= cfg_data[7:0];
        twma_pkg::REG_X_UPPER:    cfg_r.x_upper    <= cfg_data[7:0];
        twma_pkg::REG_Y_LOWER:    cfg_r.y_lower    <= cfg_data[7:0];
        twma_pkg::REG_Y_UPPER:    cfg_r.y_upper    <= cfg_data[7:0];
        twma_pkg::REG_SLOPE:      cfg_r.slope      <= cfg_data[7:0];
        default:                  cfg_r            <= cfg_r;
      endcase
    end
  end

  twma_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  twma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  twma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .gain      (cfg_r.gain),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/twma_front.sv =====
// Front part: accepts ticks, runs the skip counter and maps both axes.
module twma_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  twma_pkg::in_item_t  in_data,
  input  twma_pkg::cfg_regs_t cfg,
  input  logic                q_full,
  output logic                q_push,
  output twma_pkg::q_item_t   q_item
);

  logic [15:0] skip_count_r;
  logic [15:0] skip_count_nxt;
  logic        taken;

  // Window map: below lower gives 0, above upper gives 255, else scaled offset
  function automatic logic [7:0] map_axis(input logic [7:0] s, input logic [7:0] lo,
                                          input logic [7:0] hi, input logic [7:0] k);
    logic [7:0]  diff;
    logic [15:0] prod;
    diff = s - lo;
    prod = diff * k;
    if (s < lo) begin
      map_axis = 8'd0;
    end else if (s > hi) begin
      map_axis = twma_pkg::SAT_MAX;
    end else begin
      map_axis = prod[7:0];
    end
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign taken    = (skip_count_r >= cfg.skip_ticks);

  // Classify the tick and push it with its mapped samples
  always_comb begin
    q_item.x_mapped = map_axis(in_data.x_sample, cfg.x_lower, cfg.x_upper, cfg.slope);
    q_item.y_mapped = map_axis(in_data.y_sample, cfg.y_lower, cfg.y_upper, cfg.slope);
    q_item.taken    = taken;
  end

  // Clear the skip count on a sampling tick, advance it otherwise
  always_comb begin
    skip_count_nxt = skip_count_r;
    if (q_push) begin
      skip_count_nxt = taken ? 16'd0 : skip_count_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= 16'd0;
    end else begin
      skip_count_r <= skip_count_nxt;
    end
  end

endmodule

// ===== hdl/twma_queue.sv =====
// Short queue of classified ticks between the front and back parts.
module twma_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  twma_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output twma_pkg::q_item_t q_item
);

  twma_pkg::q_item_t                   entry_r [twma_pkg::Q_DEPTH];
  logic [twma_pkg::QP_W-1:0]           wr_ptr_r;
  logic [twma_pkg::QP_W-1:0]           wr_ptr_nxt;
  logic [twma_pkg::QP_W-1:0]           rd_ptr_r;
  logic [twma_pkg::QP_W-1:0]           rd_ptr_nxt;
  logic [twma_pkg::QC_W-1:0]           count_r;
  logic [twma_pkg::QC_W-1:0]           count_nxt;

  localparam logic [twma_pkg::QP_W-1:0] PTR_LAST = twma_pkg::QP_W'(twma_pkg::Q_DEPTH - 1);

  assign full    = (count_r == twma_pkg::QC_W'(twma_pkg::Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/twma_back.sv =====
// Back part: ring stores, running sums, gain and the output register.
module twma_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  twma_pkg::q_item_t    q_item,
  output logic                 q_pop,
  input  logic [7:0]           gain,
  output logic                 out_valid,
  input  logic                 out_ready,
  output twma_pkg::out_item_t  out_data
);

  localparam logic [twma_pkg::SLOT_W-1:0] SLOT_LAST =
    twma_pkg::SLOT_W'(twma_pkg::AVG_DEPTH - 1);
  localparam logic [twma_pkg::SUM_W-1:0] SUM_MAX =
    twma_pkg::SUM_W'(255 * twma_pkg::AVG_DEPTH);

  twma_pkg::back_state_t state_r;
  twma_pkg::back_state_t state_nxt;

  logic [7:0] x_mem [twma_pkg::AVG_DEPTH];
  logic [7:0] y_mem [twma_pkg::AVG_DEPTH];
  logic [twma_pkg::AVG_DEPTH-1:0] vld_r;
  logic [7:0] x_rd_r;
  logic [7:0] y_rd_r;
  logic       rd_vld_r;

  twma_pkg::q_item_t              item_r;
  logic [twma_pkg::SLOT_W-1:0]    slot_r;
  logic [twma_pkg::SLOT_W-1:0]    slot_nxt;
  logic [twma_pkg::SUM_W-1:0]     x_sum_r;
  logic [twma_pkg::SUM_W-1:0]     y_sum_r;
  logic [twma_pkg::SUM_W-1:0]     x_sum_upd;
  logic [twma_pkg::SUM_W-1:0]     y_sum_upd;
  logic [twma_pkg::SUM_W-1:0]     x_sum_src;
  logic [twma_pkg::SUM_W-1:0]     y_sum_src;
  logic [7:0]                     x_old;
  logic [7:0]                     y_old;

  logic                 out_valid_r;
  twma_pkg::out_item_t  out_data_r;
  twma_pkg::out_item_t  out_data_nxt;
  logic                 out_free;

  // Sequencer controls
  logic rd_en;
  logic wr_en;
  logic out_load;

  // Average times gain, saturated
  function automatic logic [7:0] scale_avg(input logic [twma_pkg::SUM_W-1:0] sum,
                                           input logic [7:0] g);
    logic [7:0]  avg;
    logic [15:0] prod;
    avg  = sum[twma_pkg::SUM_W-1:twma_pkg::SLOT_W];
    prod = avg * g;
    scale_avg = (prod > 16'(twma_pkg::SAT_MAX)) ? twma_pkg::SAT_MAX : prod[7:0];
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Swap the oldest entry for the new one in each running sum
  assign x_old     = rd_vld_r ? x_rd_r : 8'd0;
  assign y_old     = rd_vld_r ? y_rd_r : 8'd0;
  assign x_sum_upd = x_sum_r - twma_pkg::SUM_W'(x_old) + twma_pkg::SUM_W'(item_r.x_mapped);
  assign y_sum_upd = y_sum_r - twma_pkg::SUM_W'(y_old) + twma_pkg::SUM_W'(item_r.y_mapped);
  assign slot_nxt  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      twma_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = q_item.taken ? twma_pkg::BK_UPDATE : twma_pkg::BK_HOLD;
        end
      end
      twma_pkg::BK_UPDATE: begin
        state_nxt = out_free ? twma_pkg::BK_IDLE : twma_pkg::BK_HOLD;
      end
      twma_pkg::BK_HOLD: begin
        if (out_free) begin
          state_nxt = twma_pkg::BK_IDLE;
        end
      end
      default: state_nxt = twma_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    x_sum_src = x_sum_r;
    y_sum_src = y_sum_r;
    unique case (state_r)
      twma_pkg::BK_IDLE: begin
        q_pop = q_valid;
        rd_en = q_valid && q_item.taken;
      end
      twma_pkg::BK_UPDATE: begin
        wr_en     = 1'b1;
        out_load  = out_free;
        x_sum_src = x_sum_upd;
        y_sum_src = y_sum_upd;
      end
      twma_pkg::BK_HOLD: begin
        out_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.x_average    = scale_avg(x_sum_src, gain);
    out_data_nxt.y_average    = scale_avg(y_sum_src, gain);
    out_data_nxt.sample_taken = item_r.taken;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twma_pkg::BK_IDLE;
      slot_r      <= '0;
      x_sum_r     <= '0;
      y_sum_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        slot_r        <= slot_nxt;
        x_sum_r       <= x_sum_upd;
        y_sum_r       <= y_sum_upd;
        vld_r[slot_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the popped item and the result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Ring stores: read the oldest entry, then write the new one back
  always_ff @(posedge clk) begin
    if (rd_en) begin
      x_rd_r   <= x_mem[slot_r];
      y_rd_r   <= y_mem[slot_r];
      rd_vld_r <= vld_r[slot_r];
    end
    if (wr_en) begin
      x_mem[slot_r] <= item_r.x_mapped;
      y_mem[slot_r] <= item_r.y_mapped;
    end
  end

`ifndef SYNTHESIS
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (x_sum_r <= SUM_MAX) && (y_sum_r <= SUM_MAX))
    else $error("running sum exceeds ring capacity");

  a_taken_goes_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twma_pkg::BK_IDLE && q_valid && q_item.taken)
      |=> (state_r == twma_pkg::BK_UPDATE))
    else $error("sampling tick did not reach the update step");

  a_update_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(slot_r)] && (slot_r != $past(slot_r)))
    else $error("ring write did not mark its slot or advance");

  a_update_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twma_pkg::BK_UPDATE && out_free) |=> out_valid_r && out_data_r.sample_taken)
    else $error("result of a sampling tick lost its sample flag");
`endif

endmodule

// ===== test/tb_two_axis_windowed_moving_average_core.sv =====
`timescale 1ns / 100ps
// Testbench of the two-axis windowed moving average core with a scoreboard predictor.
module tb_two_axis_windowed_moving_average_core;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 228;
  localparam int NUM_PHASES   = 8;
  localparam int MAX_REPORTS  = 10;

  // Predicts the averaged outputs and holds them until the core delivers them
  class avg_scoreboard;
    logic [15:0] skip_ticks;
    logic [7:0]  gain;
    logic [7:0]  x_lower;
    logic [7:0]  x_upper;
    logic [7:0]  y_lower;
    logic [7:0]  y_upper;
    logic [7:0]  slope;
    logic [7:0]  x_ring [twma_pkg::AVG_DEPTH];
    logic [7:0]  y_ring [twma_pkg::AVG_DEPTH];
    int unsigned x_sum;
    int unsigned y_sum;
    logic [twma_pkg::SLOT_W-1:0] write_slot;
    logic [15:0] skip_count;
    twma_pkg::out_item_t average_q [$];
    int unsigned errors;

    function new();
      skip_ticks = twma_pkg::RST_SKIP_TICKS;
      gain       = twma_pkg::RST_GAIN;
      x_lower    = twma_pkg::RST_X_LOWER;
      x_upper    = twma_pkg::RST_X_UPPER;
      y_lower    = twma_pkg::RST_Y_LOWER;
      y_upper    = twma_pkg::RST_Y_UPPER;
      slope      = twma_pkg::RST_SLOPE;
      foreach (x_ring[i]) begin
        x_ring[i] = 8'd0;
        y_ring[i] = 8'd0;
      end
      x_sum      = 0;
      y_sum      = 0;
      write_slot = '0;
      skip_count = 16'd0;
      errors     = 0;
    endfunction

    function void set_reg(twma_pkg::cfg_reg_t idx, logic [twma_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        twma_pkg::REG_SKIP_TICKS: skip_ticks = val;
        twma_pkg::REG_GAIN:       gain       = val[7:0];
        twma_pkg::REG_X_LOWER:    x_lower    = val[7:0];
        twma_pkg::REG_X_UPPER:    x_upper    = val[7:0];
        twma_pkg::REG_Y_LOWER:    y_lower    = val[7:0];
        twma_pkg::REG_Y_UPPER:    y_upper    = val[7:0];
        twma_pkg::REG_SLOPE:      slope      = val[7:0];
        default: ;
      endcase
    endfunction

    // Lower bound is tested first, so an inverted window gives 0 or full scale
    function logic [7:0] map_sample(logic [7:0] s, logic [7:0] lo, logic [7:0] hi);
      logic [15:0] prod;
      prod = (s - lo) * slope;
      if (s < lo) return 8'd0;
      if (s > hi) return twma_pkg::SAT_MAX;
      return prod[7:0];
    endfunction

    function logic [7:0] scaled_avg(int unsigned sum);
      int unsigned v;
      v = (sum / twma_pkg::AVG_DEPTH) * 32'(gain);
      return (v > 255) ? twma_pkg::SAT_MAX : v[7:0];
    endfunction

    // Advance the skip counter and rings for one accepted tick
    function void note_input(twma_pkg::in_item_t it);
      twma_pkg::out_item_t predicted;
      logic [7:0] mx;
      logic [7:0] my;
      predicted.sample_taken = 1'b0;
      if (skip_count >= skip_ticks) begin
        skip_count = 16'd0;
        mx = map_sample(it.x_sample, x_lower, x_upper);
        my = map_sample(it.y_sample, y_lower, y_upper);
        x_sum = x_sum - 32'(x_ring[write_slot]) + 32'(mx);
        y_sum = y_sum - 32'(y_ring[write_slot]) + 32'(my);
        x_ring[write_slot] = mx;
        y_ring[write_slot] = my;
        write_slot = (write_slot == twma_pkg::SLOT_W'(twma_pkg::AVG_DEPTH - 1)) ?
                     '0 : write_slot + 1'b1;
        predicted.sample_taken = 1'b1;
      end else begin
        skip_count = skip_count + 16'd1;
      end
      predicted.x_average = scaled_avg(x_sum);
      predicted.y_average = scaled_avg(y_sum);
      average_q.push_back(predicted);
    endfunction

    function void check_result(twma_pkg::out_item_t got);
      twma_pkg::out_item_t want;
      if (average_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected item x=%0d y=%0d taken=%0b", $time,
                   got.x_average, got.y_average, got.sample_taken);
        return;
      end
      want = average_q.pop_front();
      if (got.x_average !== want.x_average || got.y_average !== want.y_average ||
          got.sample_taken !== want.sample_taken) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch expected x=%0d y=%0d taken=%0b, got x=%0d y=%0d taken=%0b",
                   $time, want.x_average, want.y_average, want.sample_taken,
                   got.x_average, got.y_average, got.sample_taken);
      end
    endfunction

    function int unsigned pending();
      return average_q.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  twma_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  twma_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [twma_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [twma_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  bit            hold_off       = 1'b0;
  int unsigned   idle_cycles    = 0;
  avg_scoreboard sb;

  two_axis_windowed_moving_average_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off entirely while requested
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Record handshakes and watch for a hung core
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(twma_pkg::cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one tick after a random gap and hold it until accepted
  task automatic send_tick(logic [7:0] x, logic [7:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{x_sample: x, y_sample: y};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Caller drops cfg_valid after the last write of a batch
  task automatic write_reg(twma_pkg::cfg_reg_t idx, logic [twma_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [15:0] skip, logic [7:0] g, logic [7:0] xl,
                                logic [7:0] xu, logic [7:0] yl, logic [7:0] yu,
                                logic [7:0] sl);
    write_reg(twma_pkg::REG_SKIP_TICKS, skip);
    write_reg(twma_pkg::REG_GAIN, 16'(g));
    write_reg(twma_pkg::REG_X_LOWER, 16'(xl));
    write_reg(twma_pkg::REG_X_UPPER, 16'(xu));
    write_reg(twma_pkg::REG_Y_LOWER, 16'(yl));
    write_reg(twma_pkg::REG_Y_UPPER, 16'(yu));
    write_reg(twma_pkg::REG_SLOPE, 16'(sl));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, let every expected average arrive, then let the core settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Samples cluster around the window edges half of the time
  function automatic logic [7:0] near_bound(logic [7:0] lo, logic [7:0] hi);
    int v;
    case ($urandom_range(3))
      0:       v = int'(lo) + int'($urandom_range(4)) - 2;
      1:       v = int'(hi) + int'($urandom_range(4)) - 2;
      default: v = int'($urandom_range(255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic apply_random_settings();
    logic [7:0] xa;
    logic [7:0] xb;
    logic [7:0] ya;
    logic [7:0] yb;
    xa = 8'($urandom_range(255));
    xb = 8'($urandom_range(255));
    ya = 8'($urandom_range(255));
    yb = 8'($urandom_range(255));
    // keep most windows ordered, leave some inverted
    if (xa > xb && $urandom_range(3) != 0) {xa, xb} = {xb, xa};
    if (ya > yb && $urandom_range(3) != 0) {ya, yb} = {yb, ya};
    apply_settings(16'($urandom_range(3)),
                   ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                              8'($urandom_range(2, 1)),
                   xa, xb, ya, yb, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(int n, int unsigned s_pct, int unsigned r_pct, bit squeeze);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    fork
      begin
        // hold off the receiver so the core backs up into its input
        if (squeeze) begin
          @(posedge clk);
          hold_off = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_off = 1'b0;
        end
      end
      begin
        for (int i = 0; i < n; i++)
          send_tick(near_bound(sb.x_lower, sb.x_upper), near_bound(sb.y_lower, sb.y_upper));
      end
    join
    wait_idle();
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: field extremes, window edges, inside values
    send_tick(8'd0, 8'd0);
    send_tick(8'd255, 8'd255);
    send_tick(8'd79, 8'd77);
    send_tick(8'd80, 8'd78);
    send_tick(8'd86, 8'd84);
    send_tick(8'd87, 8'd85);
    send_tick(8'd81, 8'd79);
    send_tick(8'd85, 8'd83);
    send_tick(8'd84, 8'd82);
    send_tick(8'd170, 8'd85);
    send_tick(8'd83, 8'd81);
    send_tick(8'd82, 8'd80);
    wait_idle();

    // Zero gain, inverted X window, skipped ticks
    write_reg(twma_pkg::REG_SKIP_TICKS, 16'd2);
    write_reg(twma_pkg::REG_GAIN, 16'd0);
    write_reg(twma_pkg::REG_X_LOWER, 16'd200);
    write_reg(twma_pkg::REG_X_UPPER, 16'd100);
    cfg_valid <= 1'b0;
    send_tick(8'd199, 8'd0);
    send_tick(8'd200, 8'd255);
    send_tick(8'd255, 8'd78);
    send_tick(8'd0, 8'd84);
    send_tick(8'd100, 8'd81);
    wait_idle();

    // Long skip, then lower it below the running count
    write_reg(twma_pkg::REG_SKIP_TICKS, 16'd7);
    write_reg(twma_pkg::REG_GAIN, 16'd3);
    cfg_valid <= 1'b0;
    send_tick(8'd210, 8'd90);
    send_tick(8'd220, 8'd80);
    send_tick(8'd230, 8'd79);
    send_tick(8'd240, 8'd82);
    wait_idle();
    write_reg(twma_pkg::REG_SKIP_TICKS, 16'd1);
    cfg_valid <= 1'b0;
    send_tick(8'd250, 8'd83);
    send_tick(8'd201, 8'd84);
    send_tick(8'd202, 8'd85);
    send_tick(8'd203, 8'd79);
    wait_idle();

    // Random phases over several settings and idling patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0)
        apply_settings(16'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255);
      else if (p == 1)
        apply_settings(16'hFFFF, 8'd0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0);
      else
        apply_random_settings();
      case (p % 4)
        0:       run_phase(PHASE_ITEMS, 0, 0, p == 4);
        1:       run_phase(PHASE_ITEMS, 55, 0, 1'b0);
        2:       run_phase(PHASE_ITEMS, 0, 55, 1'b0);
        default: run_phase(PHASE_ITEMS, 23, 23, 1'b0);
      endcase
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
